// ===== rtl/core/ood_pkg.sv =====
// ----------------------------------------------------------------------------
// ood_pkg
// Shared types and constants for the oscillator octave/DAC code generator.
// ----------------------------------------------------------------------------
package ood_pkg;

    localparam int FREQ_W   = 26;
    localparam int OCT_W    = 4;
    localparam int OFF_W    = 10;
    localparam int CODE_W   = 16;
    localparam int DNUM_W   = 38;
    localparam int DDEN_W   = FREQ_W + 1;
    localparam int DQUO_W   = OFF_W + 1;
    localparam int RDEN_W   = 12;
    localparam int RQUO_W   = 28;

    localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(40000000);
    localparam logic [FREQ_W-1:0] BASE_HZ  = FREQ_W'(1039);
    localparam logic [DNUM_W-1:0] OSC_NUM  = DNUM_W'(2078);
    localparam logic [RDEN_W-1:0] DAC_SPAN = RDEN_W'(2048);
    localparam logic [OFF_W-1:0]  OFF_MAX  = OFF_W'(1023);
    localparam logic [OCT_W-1:0]  OCT_TOP  = OCT_W'(15);
    localparam int OSC_BASE_SHIFT = 10;
    localparam int RECIP_SHIFT    = 26;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic              en;
        logic              low;
        logic [OCT_W-1:0]  oct;
        logic [DNUM_W-1:0] num;
        logic [FREQ_W-1:0] f;
    } item_t;

    // Sideband carried through the offset divider.
    typedef struct packed {
        logic             en;
        logic             low;
        logic [OCT_W-1:0] oct;
    } side1_t;

    // Sideband carried through the reciprocal divider.
    typedef struct packed {
        logic             en;
        logic             low;
        logic [OCT_W-1:0] oct;
        logic [OFF_W-1:0] off;
    } side2_t;

endpackage

// ===== rtl/core/ood_front.sv =====
// ----------------------------------------------------------------------------
// ood_front
// Clamps the request, picks the octave and forms the offset dividend.
// ----------------------------------------------------------------------------
module ood_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         freq_valid,
    output logic                         freq_stall,
    input  logic [ood_pkg::FREQ_W-1:0]   freq_hz,
    output logic                         item_valid,
    output ood_pkg::item_t               item,
    input  logic                         item_ready
);

    logic                          valid_reg;
    ood_pkg::item_t                item_reg;
    ood_pkg::item_t                item_next;
    logic                          take;
    logic [ood_pkg::FREQ_W-1:0]    f_clamp;
    logic [ood_pkg::OCT_W-1:0]     oct;
    logic [15:1]                   ge;
    logic [ood_pkg::DNUM_W-1:0]    osc;
    logic [ood_pkg::DNUM_W-1:0]    f_wide;

    assign freq_stall = valid_reg && !item_ready;
    assign take       = freq_valid && !freq_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        f_clamp = (freq_hz > ood_pkg::FREQ_MAX) ? ood_pkg::FREQ_MAX : freq_hz;
        f_wide  = ood_pkg::DNUM_W'(f_clamp);
        for (int k = 1; k <= 15; k++)
        begin
            ge[k] = (ood_pkg::DNUM_W'(ood_pkg::BASE_HZ) << k) <= f_wide;
        end
        oct = '0;
        for (int k = 1; k <= 15; k++)
        begin
            if (ge[k])
            begin
                oct = ood_pkg::OCT_W'(k);
            end
        end
        osc = ood_pkg::OSC_NUM << (5'(ood_pkg::OSC_BASE_SHIFT) + 5'(oct));
        // Dividend 2*(2048*f - osc) + f, divisor 2*f gives the rounded offset.
        item_next.num = (f_wide << 12) + f_wide - (osc << 1);
        item_next.f   = f_clamp;
        item_next.oct = oct;
        item_next.low = f_clamp < ood_pkg::BASE_HZ;
        item_next.en  = freq_hz != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!freq_stall)
        begin
            valid_reg <= freq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/core/ood_queue.sv =====
// ----------------------------------------------------------------------------
// ood_queue
// Small FIFO that decouples the front end from the divider back end.
// ----------------------------------------------------------------------------
module ood_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  ood_pkg::item_t push_item,
    output logic           push_ready,
    output logic           pop_valid,
    output ood_pkg::item_t pop_item,
    input  logic           pop_take
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ood_pkg::item_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  rd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              push;
    logic              pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = slot_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_take && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

    property p_no_overfill;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= CNT_W'(DEPTH);
    endproperty
    a_no_overfill: assert property (p_no_overfill) else $error("queue overfilled");

    property p_empty_no_pop;
        @(posedge clk) disable iff (!rst_n) (cnt_reg == '0) |-> !pop;
    endproperty
    a_empty_no_pop: assert property (p_empty_no_pop) else $error("pop from empty queue");

    property p_count_tracks;
        @(posedge clk) disable iff (!rst_n)
            (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1);
    endproperty
    a_count_tracks: assert property (p_count_tracks) else $error("queue count slip");

endmodule

// ===== rtl/core/ood_div.sv =====
// ----------------------------------------------------------------------------
// ood_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ood_div
#(
    parameter int NW = 38,
    parameter int DW = 27,
    parameter int QW = 11,
    parameter int SW = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] out_side
);

    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic [RW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] valid_reg;

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [RW-1:0] rem_src;
        logic [DW-1:0] den_src;
        logic [QW-1:0] quo_src;
        logic [SW-1:0] side_src;
        logic          valid_src;
        logic [RW-1:0] dsh;
        logic          ge;
        logic [QW-1:0] quo_st;

        if (s == 0)
        begin : g_first
            assign rem_src   = RW'(num);
            assign den_src   = den;
            assign quo_src   = '0;
            assign side_src  = side;
            assign valid_src = in_valid;
        end
        else
        begin : g_next
            assign rem_src   = rem_reg[s-1];
            assign den_src   = den_reg[s-1];
            assign quo_src   = quo_reg[s-1];
            assign side_src  = side_reg[s-1];
            assign valid_src = valid_reg[s-1];
        end

        always_comb
        begin
            dsh    = RW'(den_src) << (QW - 1 - s);
            ge     = rem_src >= dsh;
            quo_st = quo_src;
            quo_st[QW-1-s] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? rem_src - dsh : rem_src;
                den_reg[s]  <= den_src;
                quo_reg[s]  <= quo_st;
                side_reg[s] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ===== rtl/core/ood_back.sv =====
// ----------------------------------------------------------------------------
// ood_back
// Offset division, saturation, reciprocal division and result register.
// ----------------------------------------------------------------------------
module ood_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    input  ood_pkg::item_t               pop_item,
    output logic                         pop_take,
    output logic                         code_valid,
    input  logic                         code_stall,
    output logic [ood_pkg::CODE_W-1:0]   code_word,
    output logic [ood_pkg::OCT_W-1:0]    octave_out,
    output logic [ood_pkg::OFF_W-1:0]    dac_offset,
    output logic                         clock_enabled,
    output logic [ood_pkg::FREQ_W-1:0]   achieved_hz
);

    localparam int S1_W = $bits(ood_pkg::side1_t);
    localparam int S2_W = $bits(ood_pkg::side2_t);

    logic                          adv;
    ood_pkg::side1_t               s1_in;
    ood_pkg::side1_t               s1_out;
    logic [S1_W-1:0]               s1_bits;
    logic                          d1_valid;
    logic [ood_pkg::DQUO_W-1:0]    q1;
    ood_pkg::side2_t               s2_in;
    ood_pkg::side2_t               s2_out;
    logic [S2_W-1:0]               s2_bits;
    logic [ood_pkg::RDEN_W-1:0]    den2;
    logic                          d2_valid;
    logic [ood_pkg::RQUO_W-1:0]    y;
    logic [ood_pkg::OCT_W-1:0]     sh;
    logic [ood_pkg::RQUO_W:0]      y_half;

    logic                          valid_reg;
    logic [ood_pkg::CODE_W-1:0]    code_reg, code_next;
    logic [ood_pkg::OCT_W-1:0]     oct_reg, oct_next;
    logic [ood_pkg::OFF_W-1:0]     off_reg, off_next;
    logic                          en_reg, en_next;
    logic [ood_pkg::FREQ_W-1:0]    ach_reg, ach_next;

    assign adv      = !valid_reg || !code_stall;
    assign pop_take = adv;

    assign s1_in.en  = pop_item.en;
    assign s1_in.low = pop_item.low;
    assign s1_in.oct = pop_item.oct;

    ood_div #(
        .NW (ood_pkg::DNUM_W),
        .DW (ood_pkg::DDEN_W),
        .QW (ood_pkg::DQUO_W),
        .SW (S1_W)
    ) u_div_off (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pop_valid),
        .num       (pop_item.num),
        .den       ({pop_item.f, 1'b0}),
        .side      (s1_in),
        .out_valid (d1_valid),
        .quo       (q1),
        .out_side  (s1_bits)
    );

    always_comb
    begin
        s1_out    = ood_pkg::side1_t'(s1_bits);
        s2_in.en  = s1_out.en;
        s2_in.low = s1_out.low;
        s2_in.oct = s1_out.oct;
        s2_in.off = (q1 > ood_pkg::DQUO_W'(ood_pkg::OFF_MAX)) ? ood_pkg::OFF_MAX
                                                            : q1[ood_pkg::OFF_W-1:0];
        den2      = ood_pkg::DAC_SPAN - ood_pkg::RDEN_W'(s2_in.off);
    end

    ood_div #(
        .NW (ood_pkg::DNUM_W),
        .DW (ood_pkg::RDEN_W),
        .QW (ood_pkg::RQUO_W),
        .SW (S2_W)
    ) u_div_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d1_valid),
        .num       (ood_pkg::OSC_NUM << ood_pkg::RECIP_SHIFT),
        .den       (den2),
        .side      (s2_in),
        .out_valid (d2_valid),
        .quo       (y),
        .out_side  (s2_bits)
    );

    always_comb
    begin
        s2_out = ood_pkg::side2_t'(s2_bits);
        sh     = ood_pkg::OCT_TOP - s2_out.oct;
        y_half = (({1'b0, y} >> sh) + 1'b1) >> 1;
        en_next = s2_out.en;
        if (!s2_out.en)
        begin
            code_next = '0;
            oct_next  = '0;
            off_next  = '0;
            ach_next  = '0;
        end
        else if (s2_out.low)
        begin
            code_next = '0;
            oct_next  = '0;
            off_next  = '0;
            ach_next  = ood_pkg::BASE_HZ;
        end
        else
        begin
            code_next = {s2_out.oct, s2_out.off, 2'b00};
            oct_next  = s2_out.oct;
            off_next  = s2_out.off;
            ach_next  = y_half[ood_pkg::FREQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_reg <= code_next;
            oct_reg  <= oct_next;
            off_reg  <= off_next;
            en_reg   <= en_next;
            ach_reg  <= ach_next;
        end
    end

    assign code_valid    = valid_reg;
    assign code_word     = code_reg;
    assign octave_out    = oct_reg;
    assign dac_offset    = off_reg;
    assign clock_enabled = en_reg;
    assign achieved_hz   = ach_reg;

    property p_code_fields;
        @(posedge clk) disable iff (!rst_n)
            valid_reg |-> (code_reg == {oct_reg, off_reg, 2'b00});
    endproperty
    a_code_fields: assert property (p_code_fields) else $error("code word fields differ");

    property p_disabled_zero;
        @(posedge clk) disable iff (!rst_n)
            (valid_reg && !en_reg) |-> (code_reg == '0 && ach_reg == '0);
    endproperty
    a_disabled_zero: assert property (p_disabled_zero) else $error("disabled result not zero");

    property p_hold_on_stall;
        @(posedge clk) disable iff (!rst_n)
            (valid_reg && code_stall) |=> (valid_reg && $stable(ach_reg));
    endproperty
    a_hold_on_stall: assert property (p_hold_on_stall) else $error("result lost on stall");

endmodule

// ===== rtl/core/oscillator_octave_dac_code.sv =====
// ----------------------------------------------------------------------------
// oscillator_octave_dac_code
// Turns a requested frequency into an octave/DAC programming word.
// ----------------------------------------------------------------------------
// A request enters on freq_hz with freq_valid; it is taken in a transfer at
// any rising edge where freq_valid is high and freq_stall is low. Each request
// gives exactly one result on the code channel, in request order, taken in a
// transfer when code_valid is high and code_stall is low.
// The front end clamps the request and registers it with its octave. A short
// queue follows, then the back end: an 11-stage divider for the rounded offset
// and a 28-stage divider for the reciprocal that yields the achieved frequency,
// then a result register. Each item passes the front register, a queue slot,
// the stages of the two dividers and the result register, in that order.
// Throughput is one request per cycle when the receiver keeps up.
// With a result valid and code_stall high, the whole back end holds still; the
// queue absorbs what the front end already took; freq_stall rises once full.
// Reset clears all valid flags and queue pointers; no result is pending after.
// ----------------------------------------------------------------------------
module oscillator_octave_dac_code
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         freq_valid,
    output logic                         freq_stall,
    input  logic [ood_pkg::FREQ_W-1:0]   freq_hz,
    output logic                         code_valid,
    input  logic                         code_stall,
    output logic [ood_pkg::CODE_W-1:0]   code_word,
    output logic [ood_pkg::OCT_W-1:0]    octave_out,
    output logic [ood_pkg::OFF_W-1:0]    dac_offset,
    output logic                         clock_enabled,
    output logic [ood_pkg::FREQ_W-1:0]   achieved_hz
);

    // Classified items between the front end and the queue.
    logic           fe_valid;
    ood_pkg::item_t fe_item;
    logic           q_ready;

    // Items between the queue and the back end.
    logic           q_valid;
    ood_pkg::item_t q_item;
    logic           be_take;

    ood_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .freq_valid (freq_valid),
        .freq_stall (freq_stall),
        .freq_hz    (freq_hz),
        .item_valid (fe_valid),
        .item       (fe_item),
        .item_ready (q_ready)
    );

    ood_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_item  (fe_item),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop_take   (be_take)
    );

    ood_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (q_valid),
        .pop_item      (q_item),
        .pop_take      (be_take),
        .code_valid    (code_valid),
        .code_stall    (code_stall),
        .code_word     (code_word),
        .octave_out    (octave_out),
        .dac_offset    (dac_offset),
        .clock_enabled (clock_enabled),
        .achieved_hz   (achieved_hz)
    );

endmodule
